### sv/lp2c_pkg.sv
// ----------------------------------------------------------------------------
// lp2c_pkg: shared constants and types for the polar to Cartesian unit
// Holds the rotation constants, field widths and the sideband item type.
// ----------------------------------------------------------------------------
package lp2c_pkg;

	localparam int QUALITY_SHIFT   = 2;
	localparam int RANGE_BITS      = 18;
	localparam int ROTATION_STAGES = 16;

	localparam int MAX_STAGES = 24;
	localparam int NUM_STAGES = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;
	localparam int SHIFT_W    = $clog2(MAX_STAGES);

	localparam int ANGLE_W   = 16;
	localparam int RANGE_W   = 18;
	localparam int RAW_Q_W   = 8;
	localparam int COORD_W   = 19;
	localparam int QUAL_W    = 6;
	localparam int USED_RANGE_W = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;

	// Q30 vector width and angle accumulator width (2^-32 turn)
	localparam int XY_W   = 33;
	localparam int Z_W    = 33;
	localparam int PROD_W = XY_W + RANGE_W + 1;
	localparam int ROUND_W = PROD_W - 30;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam logic signed [XY_W-1:0] INIT_X =
		XY_W'(GAIN_Q30 + ((GAIN_Q30 * 2 / 3) >>> (2 * NUM_STAGES)));

	localparam logic [ROUND_W-1:0] COORD_MAX = ROUND_W'(262143);
	localparam logic [QUAL_W-1:0]  QUAL_MAX  = '1;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN32 [MAX_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Data that rides along the rotation chain untouched
	typedef struct packed {
		quad_t                     quad;
		logic [USED_RANGE_W-1:0]   range;
		logic [QUAL_W-1:0]         qual;
	} side_t;

	function automatic logic [QUAL_W-1:0] qual_sat(input logic [RAW_Q_W-1:0] raw);
		logic [RAW_Q_W-1:0] sh;
		sh = raw >> QUALITY_SHIFT;
		if (sh > RAW_Q_W'(QUAL_MAX))
			return QUAL_MAX;
		return sh[QUAL_W-1:0];
	endfunction

endpackage

### sv/lp2c_cell.sv
// ----------------------------------------------------------------------------
// lp2c_cell: one micro-rotation of the vector chain
// Rotates toward zero residual angle and registers the item for the next cell.
// ----------------------------------------------------------------------------
module lp2c_cell import lp2c_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SHIFT_W-1:0]     shift,
	input  logic [31:0]            atan_step,
	input  logic                   in_valid,
	input  logic signed [XY_W-1:0] in_x,
	input  logic signed [XY_W-1:0] in_y,
	input  logic signed [Z_W-1:0]  in_z,
	input  side_t                  in_side,
	output logic                   out_valid,
	output logic signed [XY_W-1:0] out_x,
	output logic signed [XY_W-1:0] out_y,
	output logic signed [Z_W-1:0]  out_z,
	output side_t                  out_side
);

	logic signed [XY_W-1:0] dx, dy;
	logic signed [Z_W-1:0]  da;
	logic                   valid_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	side_t                  side_q;

	assign dx = in_y >>> shift;
	assign dy = in_x >>> shift;
	assign da = $signed({1'b0, atan_step});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// advance the item; a non-negative residual rotates counterclockwise
	always_ff @(posedge clk) begin
		if (!in_z[Z_W-1]) begin
			x_q <= in_x - dx;
			y_q <= in_y + dy;
			z_q <= in_z - da;
		end else begin
			x_q <= in_x + dx;
			y_q <= in_y - dy;
			z_q <= in_z + da;
		end
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

endmodule

### sv/lp2c_scale.sv
// ----------------------------------------------------------------------------
// lp2c_scale: quadrant fold, range multiply, rounding and saturation
// Two pipeline stages: products, then rounded and clipped coordinates.
// ----------------------------------------------------------------------------
module lp2c_scale import lp2c_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [XY_W-1:0]    in_x,
	input  logic signed [XY_W-1:0]    in_y,
	input  side_t                     in_side,
	output logic                      out_valid,
	output logic signed [COORD_W-1:0] out_xc,
	output logic signed [COORD_W-1:0] out_yc,
	output logic [QUAL_W-1:0]         out_qual
);

	logic signed [XY_W-1:0]     cos_v, sin_v;
	logic signed [RANGE_W:0]    d_s;
	logic                       valid_s1, valid_s2;
	logic signed [PROD_W-1:0]   px_s1, py_s1;
	logic [QUAL_W-1:0]          qual_s1, qual_s2;
	logic signed [COORD_W-1:0]  xc_s2, yc_s2;

	function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0]  mag;
		logic [PROD_W-1:0]  sum;
		logic [ROUND_W-1:0] r;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		sum = mag + (PROD_W'(1) << 29);
		r   = sum[PROD_W-1:30];
		if (r > COORD_MAX)
			r = COORD_MAX;
		return p[PROD_W-1] ? -$signed(r[COORD_W-1:0]) : $signed(r[COORD_W-1:0]);
	endfunction

	// fold the first-quadrant result into the full turn
	always_comb begin
		case (in_side.quad)
			QUAD_0: begin cos_v = in_x;  sin_v = in_y;  end
			QUAD_1: begin cos_v = -in_y; sin_v = in_x;  end
			QUAD_2: begin cos_v = -in_x; sin_v = -in_y; end
			QUAD_3: begin cos_v = in_y;  sin_v = -in_x; end
			default: begin cos_v = in_x; sin_v = in_y;  end
		endcase
	end

	assign d_s = $signed({1'b0, RANGE_W'(in_side.range)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// widen both operands first so the full product survives
	always_ff @(posedge clk) begin
		px_s1   <= PROD_W'(d_s) * PROD_W'(cos_v);
		py_s1   <= PROD_W'(d_s) * PROD_W'(sin_v);
		qual_s1 <= in_side.qual;
		xc_s2   <= round_sat(px_s1);
		yc_s2   <= round_sat(py_s1);
		qual_s2 <= qual_s1;
	end

	assign out_valid = valid_s2;
	assign out_xc    = xc_s2;
	assign out_yc    = yc_s2;
	assign out_qual  = qual_s2;

endmodule

### sv/lidar_polar_to_cartesian_unit.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_unit: lidar polar sample to Cartesian point
// Throughput: one item per cycle; busy stays low, every cell advances each cycle.
// The row of rotation cells plus the two scaling stages sets the latency.
// Reset clears only the valid bits along the chain; no item is in flight after it.
// The receiver cannot stall: each result shows on done for exactly one cycle.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian_unit import lp2c_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ANGLE_W-1:0]        angle_code,
	input  logic [RANGE_W-1:0]        range_quarter_mm,
	input  logic [RAW_Q_W-1:0]        raw_quality,
	output logic                      done,
	output logic signed [COORD_W-1:0] x_quarter_mm,
	output logic signed [COORD_W-1:0] y_quarter_mm,
	output logic [QUAL_W-1:0]         quality_level
);

	localparam int LATENCY = NUM_STAGES + 2;

	// chain taps: entry 0 is the fresh item, entry k the output of cell k-1
	logic                   tap_valid [NUM_STAGES+1];
	logic signed [XY_W-1:0] tap_x     [NUM_STAGES+1];
	logic signed [XY_W-1:0] tap_y     [NUM_STAGES+1];
	logic signed [Z_W-1:0]  tap_z     [NUM_STAGES+1];
	side_t                  tap_side  [NUM_STAGES+1];

	// the pipeline never holds off an item
	assign busy = 1'b0;

	// seed the chain: gain-corrected unit vector, angle within the quadrant
	// scaled to 2^-32 turn, quadrant and the other fields kept as sideband
	assign tap_valid[0]      = start && !busy;
	assign tap_x[0]          = INIT_X;
	assign tap_y[0]          = '0;
	assign tap_z[0]          = $signed(Z_W'({angle_code[ANGLE_W-3:0], 16'h0000}));
	assign tap_side[0].quad  = quad_t'(angle_code[ANGLE_W-1:ANGLE_W-2]);
	assign tap_side[0].range = range_quarter_mm[USED_RANGE_W-1:0];
	assign tap_side[0].qual  = qual_sat(raw_quality);

	// one cell per micro-rotation; each shifts by its own index
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
		lp2c_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (SHIFT_W'(i)),
			.atan_step (ATAN_TURN32[i]),
			.in_valid  (tap_valid[i]),
			.in_x      (tap_x[i]),
			.in_y      (tap_y[i]),
			.in_z      (tap_z[i]),
			.in_side   (tap_side[i]),
			.out_valid (tap_valid[i+1]),
			.out_x     (tap_x[i+1]),
			.out_y     (tap_y[i+1]),
			.out_z     (tap_z[i+1]),
			.out_side  (tap_side[i+1])
		);
	end

	// the residual angle of the last cell is no longer needed
	lp2c_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tap_valid[NUM_STAGES]),
		.in_x      (tap_x[NUM_STAGES]),
		.in_y      (tap_y[NUM_STAGES]),
		.in_side   (tap_side[NUM_STAGES]),
		.out_valid (done),
		.out_xc    (x_quarter_mm),
		.out_yc    (y_quarter_mm),
		.out_qual  (quality_level)
	);

	// every result stems from an accepted item that passed the cells and the scaling stages
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching accepted item");

	// a zero distance gives the origin whatever the angle
	a_zero_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && (range_quarter_mm[USED_RANGE_W-1:0] == '0), LATENCY))
		|-> (x_quarter_mm == '0) && (y_quarter_mm == '0))
		else $error("nonzero point for zero distance");

	// quality travels untouched along the chain
	a_quality: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> quality_level == $past(qual_sat(raw_quality), LATENCY))
		else $error("quality level mismatch");

	// saturation is symmetric: the most negative code never appears
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (x_quarter_mm != -19'sd262144) && (y_quarter_mm != -19'sd262144))
		else $error("coordinate outside saturated range");

endmodule
